### src/pstt_pkg.sv
package pstt_pkg;

	// coordinate and step widths
	localparam int COORD_BITS = 16;
	localparam int STEP_BITS  = 8;

	// derived widths of the datapath
	localparam int ABS_W  = COORD_BITS;              // |target - current|
	localparam int SQ_W   = 2 * COORD_BITS;          // one squared offset
	localparam int SUM_W  = 2 * COORD_BITS + 1;      // dx^2 + dy^2
	localparam int SS_W   = 2 * STEP_BITS;           // step^2
	localparam int RHS_W  = SQ_W + SS_W;             // step^2 * d^2
	localparam int TRY_W  = RHS_W + 1;               // trial k^2 * sum
	localparam int KS_W   = SUM_W + STEP_BITS;       // k * sum
	localparam int EXT_W  = COORD_BITS + 2;          // coordinate plus step

	localparam int SEARCH_STAGES = STEP_BITS;
	localparam int PIPE_STAGES   = SEARCH_STAGES + 4;
	localparam int SEARCH_FIRST  = 4;

	localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(5);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [STEP_BITS-1:0]  step_t;

	// per-stage load enables of one axis search
	typedef struct packed {
		logic [SEARCH_STAGES-1:0] en;
	} search_ctl_t;

	// fields that ride alongside the arithmetic
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		logic   neg_x;
		logic   neg_y;
		logic   at;
	} side_t;

	// clamp to the signed coordinate range
	function automatic coord_t sat_coord(input logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		hi = EXT_W'((1 << (COORD_BITS - 1)) - 1);
		lo = -hi - EXT_W'(1);
		if (v > hi) begin
			sat_coord = hi[COORD_BITS-1:0];
		end else if (v < lo) begin
			sat_coord = lo[COORD_BITS-1:0];
		end else begin
			sat_coord = v[COORD_BITS-1:0];
		end
	endfunction

endpackage

### src/pstt_axis_search.sv
module pstt_axis_search (
	input  logic                                clk,
	input  pstt_pkg::search_ctl_t               ctl,
	input  logic [pstt_pkg::RHS_W-1:0]          rhs,
	input  logic [pstt_pkg::SUM_W-1:0]          sum,
	output logic [pstt_pkg::STEP_BITS-1:0]      k
);

	localparam int NS = pstt_pkg::SEARCH_STAGES;

	// stage registers: k so far, k^2*sum, k*sum, and the operands
	logic [pstt_pkg::STEP_BITS-1:0] k_s   [1:NS];
	logic [pstt_pkg::RHS_W-1:0]     p_s   [1:NS-1];
	logic [pstt_pkg::KS_W-1:0]      q_s   [1:NS-1];
	logic [pstt_pkg::RHS_W-1:0]     rhs_s [1:NS-1];
	logic [pstt_pkg::SUM_W-1:0]     sum_s [1:NS-1];

	genvar i;
	generate
		for (i = 0; i < NS; i++) begin : g_stage
			localparam int B = NS - 1 - i;

			logic [pstt_pkg::STEP_BITS-1:0] k_cur;
			logic [pstt_pkg::RHS_W-1:0]     p_cur;
			logic [pstt_pkg::KS_W-1:0]      q_cur;
			logic [pstt_pkg::RHS_W-1:0]     rhs_cur;
			logic [pstt_pkg::SUM_W-1:0]     sum_cur;
			logic [pstt_pkg::TRY_W-1:0]     trial;
			logic                           take;

			// select the stage source
			if (i == 0) begin : g_src_in
				assign k_cur   = '0;
				assign p_cur   = '0;
				assign q_cur   = '0;
				assign rhs_cur = rhs;
				assign sum_cur = sum;
			end else begin : g_src_reg
				assign k_cur   = k_s[i];
				assign p_cur   = p_s[i];
				assign q_cur   = q_s[i];
				assign rhs_cur = rhs_s[i];
				assign sum_cur = sum_s[i];
			end

			// try setting bit B: (k + 2^B)^2 * sum = p + q*2^(B+1) + sum*2^(2B)
			assign trial = pstt_pkg::TRY_W'(p_cur)
				+ (pstt_pkg::TRY_W'(q_cur) << (B + 1))
				+ (pstt_pkg::TRY_W'(sum_cur) << (2 * B));
			assign take  = (trial <= pstt_pkg::TRY_W'(rhs_cur));

			// advance one bit of the search
			always_ff @(posedge clk) begin
				if (ctl.en[i]) begin
					if (take) begin
						k_s[i+1] <= k_cur | (pstt_pkg::STEP_BITS'(1) << B);
					end else begin
						k_s[i+1] <= k_cur;
					end
				end
			end

			// forward the partial products and operands to the next bit
			if (i < NS - 1) begin : g_fwd
				always_ff @(posedge clk) begin
					if (ctl.en[i]) begin
						if (take) begin
							p_s[i+1] <= trial[pstt_pkg::RHS_W-1:0];
							q_s[i+1] <= q_cur + (pstt_pkg::KS_W'(sum_cur) << B);
						end else begin
							p_s[i+1] <= p_cur;
							q_s[i+1] <= q_cur;
						end
						rhs_s[i+1] <= rhs_cur;
						sum_s[i+1] <= sum_cur;
					end
				end
			end
		end
	endgenerate

	assign k = k_s[NS];

endmodule

### src/point_step_toward_target_core.sv
// Moves a point one fixed-length step along the line toward a target point.
// Input channel: in_valid / in_stall with current_x, current_y, target_x,
// target_y. Output channel: out_valid / out_stall with new_x, new_y and
// at_target. A transaction completes on an edge where valid is high and
// stall is low. Configuration: cfg_valid / cfg_ready / cfg_data write the
// step length; cfg_ready is always high. Write it only while the block is
// empty.
// The pipeline has 12 register stages. It accepts one transaction per cycle
// while in_stall is low: a fully pipelined chain of offset, squares,
// products, an 8-stage bit-by-bit search for each axis step (one step bit
// per stage), and a saturating output stage.
// Each stage loads when it is empty or the next stage loads, so bubbles
// close up under out_stall and in_stall rises only when all 12 stages hold
// transactions and the output is stalled.
// Reset empties the pipeline and sets the step length to 5.
module point_step_toward_target_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  pstt_pkg::coord_t        current_x,
	input  pstt_pkg::coord_t        current_y,
	input  pstt_pkg::coord_t        target_x,
	input  pstt_pkg::coord_t        target_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output pstt_pkg::coord_t        new_x,
	output pstt_pkg::coord_t        new_y,
	output logic                    at_target,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  pstt_pkg::step_t         cfg_data
);

	localparam int NP = pstt_pkg::PIPE_STAGES;
	localparam int SF = pstt_pkg::SEARCH_FIRST;
	localparam int NS = pstt_pkg::SEARCH_STAGES;

	pstt_pkg::step_t step_q;

	logic             valid_s [1:NP];
	logic             en      [1:NP];
	pstt_pkg::side_t  side_s  [1:NP-1];

	logic [pstt_pkg::ABS_W-1:0] ax_s1, ay_s1;
	logic [pstt_pkg::SQ_W-1:0]  ax2_s2, ay2_s2;
	logic [pstt_pkg::SS_W-1:0]  ss_s2;
	logic [pstt_pkg::SUM_W-1:0] sum_s3;
	logic [pstt_pkg::RHS_W-1:0] rx_s3, ry_s3;

	pstt_pkg::coord_t new_x_s12, new_y_s12;
	logic             at_s12;

	logic signed [pstt_pkg::COORD_BITS:0] dx, dy;
	pstt_pkg::search_ctl_t               sctl;
	logic [pstt_pkg::STEP_BITS-1:0]      kx, ky;
	logic signed [pstt_pkg::EXT_W-1:0]   ext_x, ext_y, mov_x, mov_y;

	// step length register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pstt_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	// load enables: a stage loads when empty or when its successor loads
	assign en[NP] = !valid_s[NP] || !out_stall;
	genvar g;
	generate
		for (g = 1; g < NP; g++) begin : g_en
			assign en[g] = !valid_s[g] || en[g+1];
		end
	endgenerate
	assign in_stall = !en[1];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NP; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				valid_s[1] <= in_valid;
			end
			for (int i = 2; i <= NP; i++) begin
				if (en[i]) begin
					valid_s[i] <= valid_s[i-1];
				end
			end
		end
	end

	// stage 1: offsets and their magnitudes
	assign dx = $signed({target_x[pstt_pkg::COORD_BITS-1], target_x})
		- $signed({current_x[pstt_pkg::COORD_BITS-1], current_x});
	assign dy = $signed({target_y[pstt_pkg::COORD_BITS-1], target_y})
		- $signed({current_y[pstt_pkg::COORD_BITS-1], current_y});

	// load stage 1 and carry the side fields down the pipe
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ax_s1        <= dx[pstt_pkg::COORD_BITS] ? pstt_pkg::ABS_W'(-dx)
				: pstt_pkg::ABS_W'(dx);
			ay_s1        <= dy[pstt_pkg::COORD_BITS] ? pstt_pkg::ABS_W'(-dy)
				: pstt_pkg::ABS_W'(dy);
			side_s[1].cx    <= current_x;
			side_s[1].cy    <= current_y;
			side_s[1].neg_x <= dx[pstt_pkg::COORD_BITS];
			side_s[1].neg_y <= dy[pstt_pkg::COORD_BITS];
			side_s[1].at    <= (dx == '0) && (dy == '0);
		end
		for (int i = 2; i < NP; i++) begin
			if (en[i]) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (en[2]) begin
			ax2_s2 <= pstt_pkg::SQ_W'(ax_s1) * pstt_pkg::SQ_W'(ax_s1);
			ay2_s2 <= pstt_pkg::SQ_W'(ay_s1) * pstt_pkg::SQ_W'(ay_s1);
			ss_s2  <= pstt_pkg::SS_W'(step_q) * pstt_pkg::SS_W'(step_q);
		end
	end

	// stage 3: sum of squares and right-hand sides
	always_ff @(posedge clk) begin
		if (en[3]) begin
			sum_s3 <= pstt_pkg::SUM_W'(ax2_s2) + pstt_pkg::SUM_W'(ay2_s2);
			rx_s3  <= pstt_pkg::RHS_W'(ss_s2) * pstt_pkg::RHS_W'(ax2_s2);
			ry_s3  <= pstt_pkg::RHS_W'(ss_s2) * pstt_pkg::RHS_W'(ay2_s2);
		end
	end

	// stages 4 to 11: per-axis step search
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			sctl.en[i] = en[SF + i];
		end
	end

	pstt_axis_search u_search_x (
		.clk (clk),
		.ctl (sctl),
		.rhs (rx_s3),
		.sum (sum_s3),
		.k   (kx)
	);

	pstt_axis_search u_search_y (
		.clk (clk),
		.ctl (sctl),
		.rhs (ry_s3),
		.sum (sum_s3),
		.k   (ky)
	);

	// stage 12: apply the step and saturate
	assign ext_x = pstt_pkg::EXT_W'($signed(side_s[NP-1].cx));
	assign ext_y = pstt_pkg::EXT_W'($signed(side_s[NP-1].cy));
	assign mov_x = side_s[NP-1].neg_x ? ext_x - $signed(pstt_pkg::EXT_W'(kx))
		: ext_x + $signed(pstt_pkg::EXT_W'(kx));
	assign mov_y = side_s[NP-1].neg_y ? ext_y - $signed(pstt_pkg::EXT_W'(ky))
		: ext_y + $signed(pstt_pkg::EXT_W'(ky));

	always_ff @(posedge clk) begin
		if (en[NP]) begin
			if (side_s[NP-1].at) begin
				new_x_s12 <= side_s[NP-1].cx;
				new_y_s12 <= side_s[NP-1].cy;
			end else begin
				new_x_s12 <= pstt_pkg::sat_coord(mov_x);
				new_y_s12 <= pstt_pkg::sat_coord(mov_y);
			end
			at_s12 <= side_s[NP-1].at;
		end
	end

	assign out_valid = valid_s[NP];
	assign new_x     = new_x_s12;
	assign new_y     = new_y_s12;
	assign at_target = at_s12;

	// input backs up only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s[1] && valid_s[SF] && valid_s[NP] && out_stall))
		else $error("input stalled with room in the pipeline");

	// the search result never exceeds the step length when there is an offset
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[NP-1] && !side_s[NP-1].at) |-> (kx <= step_q && ky <= step_q))
		else $error("axis step larger than step length");

	// a held result stays valid and keeps at_target while stalled
	a_hold_at: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(at_target)))
		else $error("stalled result changed");

endmodule

### bench/tb.sv
module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 2 * pstt_pkg::PIPE_STAGES + 4;
	localparam int PHASE_ITEMS  = 240;
	localparam int PHASE_COUNT  = 8;

	typedef struct packed {
		pstt_pkg::coord_t x;
		pstt_pkg::coord_t y;
		logic             at;
	} moved_point_t;

	// Predict each move and check results in order of arrival
	class step_scoreboard;
		pstt_pkg::step_t step_len;
		moved_point_t    expected_q[$];
		int              mismatches;
		int              checked;

		function new();
			step_len   = pstt_pkg::STEP_RESET;
			mismatches = 0;
			checked    = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// largest k <= step with k^2 * sum <= step^2 * d^2, signed move, clamp
		function pstt_pkg::coord_t advance_axis(longint c, longint d, longint sum);
			longint mag;
			longint rhs;
			longint k;
			longint moved;
			longint hi;
			longint lo;
			mag = (d < 0) ? -d : d;
			rhs = longint'(step_len) * longint'(step_len) * mag * mag;
			k = longint'(step_len);
			while (k > 0 && k * k * sum > rhs) begin
				k--;
			end
			moved = (d < 0) ? c - k : c + k;
			hi = (longint'(1) << (pstt_pkg::COORD_BITS - 1)) - 1;
			lo = -hi - 1;
			if (moved > hi) begin
				moved = hi;
			end else if (moved < lo) begin
				moved = lo;
			end
			return pstt_pkg::coord_t'(moved);
		endfunction

		function void note_request(pstt_pkg::coord_t cx, pstt_pkg::coord_t cy,
			pstt_pkg::coord_t tx, pstt_pkg::coord_t ty);
			longint       x0;
			longint       y0;
			longint       dx;
			longint       dy;
			longint       sum;
			moved_point_t res;
			x0 = longint'($signed(cx));
			y0 = longint'($signed(cy));
			dx = longint'($signed(tx)) - x0;
			dy = longint'($signed(ty)) - y0;
			res.x  = cx;
			res.y  = cy;
			res.at = 1'b1;
			if (dx != 0 || dy != 0) begin
				sum    = dx * dx + dy * dy;
				res.x  = advance_axis(x0, dx, sum);
				res.y  = advance_axis(y0, dy, sum);
				res.at = 1'b0;
			end
			expected_q.push_back(res);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch %0d: %s", mismatches, msg);
		endtask

		task check_result(pstt_pkg::coord_t x, pstt_pkg::coord_t y, logic at);
			moved_point_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result (%0d,%0d,%0b) with nothing outstanding",
					$signed(x), $signed(y), at));
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (x !== want.x) begin
					report_mismatch($sformatf("new_x got %0d want %0d",
						$signed(x), $signed(want.x)));
				end
				if (y !== want.y) begin
					report_mismatch($sformatf("new_y got %0d want %0d",
						$signed(y), $signed(want.y)));
				end
				if (at !== want.at) begin
					report_mismatch($sformatf("at_target got %0b want %0b", at, want.at));
				end
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	pstt_pkg::coord_t current_x = '0;
	pstt_pkg::coord_t current_y = '0;
	pstt_pkg::coord_t target_x = '0;
	pstt_pkg::coord_t target_y = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	pstt_pkg::coord_t new_x;
	pstt_pkg::coord_t new_y;
	logic             at_target;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	pstt_pkg::step_t  cfg_data = '0;

	step_scoreboard sb;
	int cycle_count = 0;
	int sent = 0;
	int settings = 0;
	int idle_odds = 0;
	int stall_odds = 0;
	int stall_left = 0;

	point_step_toward_target_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.current_x (current_x),
		.current_y (current_y),
		.target_x  (target_x),
		.target_y  (target_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_x     (new_x),
		.new_y     (new_y),
		.at_target (at_target),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outstanding", cycle_count, sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	// Stall the output in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(new_x, new_y, at_target);
		end
	end

	// Drive one point transaction, hold it until accepted, then log it
	task automatic send_point(input int cx, input int cy, input int tx, input int ty);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		current_x <= pstt_pkg::coord_t'(cx);
		current_y <= pstt_pkg::coord_t'(cy);
		target_x  <= pstt_pkg::coord_t'(tx);
		target_y  <= pstt_pkg::coord_t'(ty);
		do @(posedge clk); while (in_stall);
		sb.note_request(pstt_pkg::coord_t'(cx), pstt_pkg::coord_t'(cy),
			pstt_pkg::coord_t'(tx), pstt_pkg::coord_t'(ty));
		sent++;
	endtask

	// Write the step length once the pipeline is empty
	task automatic write_step(input pstt_pkg::step_t value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.step_len = value;
		settings++;
	endtask

	function automatic int any_coord();
		pstt_pkg::coord_t r;
		r = pstt_pkg::coord_t'($urandom);
		return int'($signed(r));
	endfunction

	function automatic int near_off(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int edge_coord();
		if ($urandom_range(0, 1) == 1) begin
			return 32767 - int'($urandom_range(0, 300));
		end
		return -32768 + int'($urandom_range(0, 300));
	endfunction

	// Pick a random transaction shape: wide, near, equal, along an axis, or at the range edge
	task automatic random_point();
		int cx;
		int cy;
		int tx;
		int ty;
		int pick;
		pick = $urandom_range(0, 99);
		cx = any_coord();
		cy = any_coord();
		tx = any_coord();
		ty = any_coord();
		if (pick < 35) begin
			// keep fully random coordinates
		end else if (pick < 65) begin
			tx = cx + near_off(300);
			ty = cy + near_off(300);
		end else if (pick < 72) begin
			tx = cx;
			ty = cy;
		end else if (pick < 82) begin
			if ($urandom_range(0, 1) == 1) begin
				tx = cx;
				if ($urandom_range(0, 1) == 1) ty = cy + near_off(200);
			end else begin
				ty = cy;
				if ($urandom_range(0, 1) == 1) tx = cx + near_off(200);
			end
		end else begin
			cx = edge_coord();
			cy = edge_coord();
			tx = (cx > 0) ? 32767 - int'($urandom_range(0, 300))
				: -32768 + int'($urandom_range(0, 300));
			ty = ($urandom_range(0, 1) == 1) ? cy + near_off(100) : edge_coord();
		end
		send_point(cx, cy, tx, ty);
	endtask

	initial begin
		pstt_pkg::step_t step_val;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transactions at the reset step length
		idle_odds  = 4;
		stall_odds = 6;
		send_point(0, 0, 0, 0);
		send_point(-32768, -32768, 32767, 32767);
		send_point(32767, 32767, -32768, -32768);
		send_point(0, 0, 3, 4);
		send_point(0, 0, 1, 0);
		send_point(10, 20, -100, 20);
		send_point(-7, 9, -7, 10009);
		send_point(32765, 0, 32767, 0);
		send_point(-32766, 5, -32768, 5);
		send_point(32767, -32768, 32767, -32768);
		send_point(0, -32768, 1, 32767);

		// zero step: nothing moves, at_target still follows the offset
		write_step(8'd0);
		send_point(0, 0, 100, -100);
		send_point(-32768, 32767, 32767, -32768);
		send_point(42, -42, 42, -42);

		// largest step: overshoot and saturation at both ends
		write_step(8'd255);
		send_point(32700, 0, 32767, 0);
		send_point(-32700, -32700, -32768, -32768);
		send_point(0, 0, 1, 1);
		send_point(-32768, -32768, 32767, 32767);
		send_point(100, 32760, 100, 32767);
		send_point(0, 0, -3, 4);

		// random phases over several step lengths, last one without idling or stalling
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: step_val = 8'd1;
				1: step_val = 8'd255;
				2: step_val = 8'd2;
				default: step_val = pstt_pkg::step_t'($urandom_range(3, 254));
			endcase
			write_step(step_val);
			if (p == PHASE_COUNT - 1) begin
				idle_odds  = 0;
				stall_odds = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_odds = 0;
					1: idle_odds = 4;
					default: idle_odds = 12;
				endcase
				case ($urandom_range(0, 2))
					0: stall_odds = 0;
					1: stall_odds = 5;
					default: stall_odds = 15;
				endcase
			end
			repeat (PHASE_ITEMS) random_point();
		end

		// drain and report
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d point transactions under %0d step length writes", sent, settings);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
